/* design/kts_pkg.sv */
`default_nettype none
package kts_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotW = $clog2(TableEntries);
  localparam int unsigned CountW = $clog2(TableEntries + 1);
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] REG_RECORD_ENABLE = 2'd0;

  localparam int unsigned EntryW = 64 + 32 + 48 + 32 + 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] name_key;
    logic [31:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] call_count;
    logic [47:0] total_us;
    logic [31:0] min_us;
    logic [31:0] max_us;
    logic [31:0] avg_us;
  } out_item_t;

  // Work item handed from the front to the back part.
  typedef struct packed {
    logic [1:0]  kind;
    logic        rec_en;
    logic [63:0] name_key;
    logic [31:0] elapsed_us;
  } work_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] calls;
    logic [47:0] total;
    logic [31:0] vmin;
    logic [31:0] vmax;
  } entry_t;

endpackage
`default_nettype wire

/* design/kts_ram.sv */
`default_nettype none
module kts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/kts_front.sv */
`default_nettype none
module kts_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire kts_pkg::in_item_t  in_item,
  input  wire logic               rec_en,
  output logic                    q_valid,
  output kts_pkg::work_t          q_item,
  input  wire logic               q_pop
);
  import kts_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  work_t             fifo_r [QueueDepth];
  logic [PtrW-1:0]   wptr_r, rptr_r;
  logic [PtrW:0]     cnt_r;
  logic              push;

  assign busy = (cnt_r == (PtrW+1)'(QueueDepth));
  // Kind 3 produces nothing, so it is dropped here.
  assign push = start && !busy && (in_item.kind != KIND_NONE);
  assign q_valid = (cnt_r != '0);
  assign q_item = fifo_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= '{kind: in_item.kind, rec_en: rec_en,
                          name_key: in_item.name_key, elapsed_us: in_item.elapsed_us};
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (q_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

/* design/kts_div.sv */
`default_nettype none
module kts_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [47:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic [33:0] sh;
  logic [33:0] diff;

  always_comb begin
    sh = {rem_r, q_r[47]};
    diff = sh - {2'b0, divisor};
    q_nxt = {q_r[46:0], !diff[33]};
    rem_nxt = diff[33] ? sh[32:0] : diff[32:0];
  end

  assign quotient = (q_r[47:32] != '0) ? 32'hFFFF_FFFF : q_r[31:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (go) begin
      q_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      done <= 1'b0;
    end else if (go) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 6'd47) begin
        run_r <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* design/kts_back.sv */
`default_nettype none
module kts_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire kts_pkg::work_t    q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  output kts_pkg::out_item_t     out_item
);
  import kts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CountW-1:0] filled_r;
  logic [CountW-1:0] idx_r;
  work_t             w_r;
  entry_t            ent_r;
  logic [SlotW-1:0]  slot_r;
  logic              we;
  logic [SlotW-1:0]  waddr;
  entry_t            wdata, rdata;
  logic              div_go, div_done;
  logic [31:0]       quot;
  logic [32:0]       calls_inc;
  logic [48:0]       tot_sum;
  entry_t            upd;
  entry_t            new_ent;
  entry_t            ent_go;
  out_item_t         err_item;

  kts_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(idx_r[SlotW-1:0]), .rdata(rdata)
  );

  // The divider loads its dividend on the go cycle, so it takes the entry
  // that is being stored into ent_r at that same edge.
  kts_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(ent_go.total),
    .divisor(ent_r.calls), .done(div_done), .quotient(quot)
  );

  always_comb begin
    calls_inc = {1'b0, rdata.calls} + 33'd1;
    tot_sum = {1'b0, rdata.total} + {17'd0, w_r.elapsed_us};
    upd.key = rdata.key;
    upd.calls = calls_inc[32] ? rdata.calls : calls_inc[31:0];
    upd.total = tot_sum[48] ? 48'hFFFF_FFFF_FFFF : tot_sum[47:0];
    upd.vmin = (w_r.elapsed_us < rdata.vmin) ? w_r.elapsed_us : rdata.vmin;
    upd.vmax = (w_r.elapsed_us > rdata.vmax) ? w_r.elapsed_us : rdata.vmax;
    new_ent = '{key: w_r.name_key, calls: 32'd1, total: {16'd0, w_r.elapsed_us},
                vmin: w_r.elapsed_us, vmax: w_r.elapsed_us};
    if (state_r == S_SCAN) begin
      ent_go = new_ent;
    end else begin
      ent_go = (w_r.kind == KIND_RECORD) ? upd : rdata;
    end
  end

  always_comb begin
    err_item = '0;
    if (w_r.kind == KIND_RECORD)
      err_item.status = w_r.rec_en ? ST_FULL : ST_DISABLED;
    else if (w_r.kind == KIND_QUERY)
      err_item.status = ST_NOT_FOUND;
    else
      err_item.status = ST_OK;
  end

  logic hit;
  assign hit = (rdata.key == w_r.name_key);

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    we = 1'b0;
    waddr = slot_r;
    wdata = upd;
    div_go = 1'b0;
    case (state_r)
      S_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (w_r.kind == KIND_CLEAR ||
            (w_r.kind == KIND_RECORD && !w_r.rec_en)) begin
          state_nxt = S_WAIT;
        end else if (idx_r >= filled_r) begin
          state_nxt = S_WAIT;
          if (w_r.kind == KIND_RECORD && filled_r != CountW'(TableEntries)) begin
            we = 1'b1;
            waddr = filled_r[SlotW-1:0];
            wdata = new_ent;
            div_go = 1'b1;
            state_nxt = S_DIV;
          end
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          if (w_r.kind == KIND_RECORD) begin
            we = 1'b1;
            waddr = idx_r[SlotW-1:0];
          end
          div_go = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DIV: if (div_done) state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (state_r == S_IDLE && q_valid) begin
      w_r <= q_item;
      idx_r <= '0;
    end
    if (state_r == S_SCAN && idx_r < filled_r) begin
      idx_r <= idx_r;
    end
    if (state_r == S_CHECK) begin
      if (hit) begin
        slot_r <= idx_r[SlotW-1:0];
        ent_r <= ent_go;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
    if (state_r == S_SCAN && state_nxt == S_DIV) begin
      slot_r <= filled_r[SlotW-1:0];
      ent_r <= ent_go;
    end
    if (state_r == S_SCAN && state_nxt == S_WAIT) begin
      out_valid <= 1'b1;
      out_item <= err_item;
    end
    if (state_r == S_DIV && div_done) begin
      out_valid <= 1'b1;
      out_item <= '{status: ST_OK, slot: 6'(slot_r), call_count: ent_r.calls,
                    total_us: ent_r.total, min_us: ent_r.vmin, max_us: ent_r.vmax,
                    avg_us: quot};
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      filled_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SCAN && w_r.kind == KIND_CLEAR)
        filled_r <= '0;
      else if (state_r == S_SCAN && state_nxt == S_DIV && idx_r >= filled_r)
        filled_r <= filled_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

/* design/keyed_timing_stats_table_core.sv */
// Channel  Ports                          Transaction
// input    start, busy, in_item           accepted when start high and busy low
// output   out_valid, out_item            one-cycle strobe, always taken
// config   cfg_psel..cfg_prdata           APB write when psel&penable&pwrite
//
// Each item is scanned one table entry at a time (RAM read, then compare);
// a hit or new entry then runs a restoring divider for the average.
// Reset clears the fill count, the queue and the enable register (to one).
// A two-entry queue lets start be taken while the back part works; the
// receiver cannot stall, so results leave the moment they are ready.
`default_nettype none
module keyed_timing_stats_table_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire kts_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output kts_pkg::out_item_t      out_item,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [1:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import kts_pkg::*;

  logic   rec_en_r;
  logic   q_valid, q_pop;
  work_t  q_item;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_RECORD_ENABLE) ? {31'd0, rec_en_r} : 32'd0;

  // The enable register is sampled into each transaction as it is queued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_en_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == REG_RECORD_ENABLE) begin
      rec_en_r <= cfg_pwdata[0];
    end
  end

  kts_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .rec_en(rec_en_r), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  kts_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

/* design/kts_checker.sv */
`default_nettype none
module kts_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire kts_pkg::out_item_t out_item
);
  import kts_pkg::*;

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");
  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.call_count == 32'd0)
    else $error("error result carries statistics");
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.call_count != 32'd0 |-> out_item.min_us <= out_item.max_us)
    else $error("min above max");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy) else $error("activity after reset");
endmodule

bind keyed_timing_stats_table_core kts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
